// ----- rtl/core/wrid_pkg.sv -----
// Shared types, codes and constants for the Remote ID element locator.
package wrid_pkg;

	localparam int LENGTH_BITS = 12;

	typedef logic [LENGTH_BITS-1:0] len_t;

	typedef struct packed {
		logic [7:0]        rx_byte;
		logic              frame_start;
		logic [11:0]       frame_length;
		logic signed [7:0] signal_strength;
	} in_t;

	typedef struct packed {
		logic              result_kind;
		logic [7:0]        payload_byte;
		logic              run_first;
		logic              run_last;
		logic [47:0]       sender_address;
		logic signed [7:0] frame_rssi;
		logic [2:0]        verdict;
	} out_t;

	typedef enum logic [2:0] {
		VRD_TOO_SHORT = 3'd0,
		VRD_NOT_MGMT  = 3'd1,
		VRD_WEAK      = 3'd2,
		VRD_SCANNED   = 3'd3,
		VRD_ACTION    = 3'd4,
		VRD_OTHER     = 3'd5
	} verdict_t;

	typedef enum logic [1:0] {
		PH_ID   = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef logic [3:0] hmatch_t;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Header match progress beyond the four header bytes.
	localparam hmatch_t HM_DONE    = 4'd4;
	localparam hmatch_t HM_PAYLOAD = 4'd5;
	localparam hmatch_t HM_SKIP    = 4'd15;

	localparam logic [7:0] VENDOR_ID   = 8'hDD;
	localparam logic [7:0] OUI_0       = 8'hFA;
	localparam logic [7:0] OUI_1       = 8'h0B;
	localparam logic [7:0] OUI_2_A     = 8'hBC;
	localparam logic [7:0] OUI_2_B     = 8'h57;
	localparam logic [7:0] ODID_TYPE_A = 8'h0D;
	localparam logic [7:0] ODID_TYPE_B = 8'h0E;
	localparam logic [7:0] MIN_VENDOR_LEN = 8'd4;

	localparam logic [1:0] FC_TYPE_MASK    = 2'h3;
	localparam logic [3:0] FC_SUBTYPE_MASK = 4'hF;
	localparam logic [3:0] SUB_BEACON      = 4'd8;
	localparam logic [3:0] SUB_PROBE_RESP  = 4'd5;
	localparam logic [3:0] SUB_ACTION      = 4'd13;

	localparam len_t MIN_FRAME_LEN = LENGTH_BITS'(24);
	localparam len_t ELEM_START    = LENGTH_BITS'(24 + 12);
	localparam len_t ADDR_FIRST    = LENGTH_BITS'(10);
	localparam len_t ADDR_LAST     = LENGTH_BITS'(15);

	localparam logic signed [7:0] RSSI_THRESHOLD_RESET = -8'sd90;

	// Which results the current transaction produces.
	typedef struct packed {
		logic pay_valid;
		logic vrd_valid;
	} emit_t;

	function automatic logic header_byte_ok(input logic [1:0] idx, input logic [7:0] b);
		logic ok;
		case (idx)
			2'd0: ok = (b == OUI_0);
			2'd1: ok = (b == OUI_1);
			2'd2: ok = (b == OUI_2_A) || (b == OUI_2_B);
			default: ok = (b == ODID_TYPE_A) || (b == ODID_TYPE_B);
		endcase
		return ok;
	endfunction

endpackage

// ----- rtl/core/wrid_out_fifo.sv -----
// Small result queue that can take two entries and give one per cycle.
module wrid_out_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_cnt,
	input  wrid_pkg::out_t             push0,
	input  wrid_pkg::out_t             push1,
	input  logic                       pop,
	output logic                       head_valid,
	output wrid_pkg::out_t             head,
	output logic [$clog2(DEPTH+1)-1:0] occupancy
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wrid_pkg::out_t entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	// Pointers wrap at the depth, which need not be a power of two.
	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] ptr, input logic [1:0] step);
		logic [PW:0] sum;
		sum = {1'b0, ptr} + (PW+1)'(step);
		if (sum >= (PW+1)'(DEPTH)) begin
			sum = sum - (PW+1)'(DEPTH);
		end
		return sum[PW-1:0];
	endfunction

	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign occupancy  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= ptr_add(wr_ptr_q, push_cnt);
			if (pop) begin
				rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
			end
			count_q <= count_q + CW'(push_cnt) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			entry_q[ptr_add(wr_ptr_q, 2'd1)] <= push1;
		end
	end

endmodule

// ----- rtl/core/wrid_parser.sv -----
// Frame classifier and tagged element walker, one frame byte per cycle.
module wrid_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  wrid_pkg::in_t         item,
	input  logic signed [7:0]     rssi_threshold,
	output wrid_pkg::emit_t       emit,
	output wrid_pkg::out_t        pay_res,
	output wrid_pkg::out_t        vrd_res
);

	localparam int LB = wrid_pkg::LENGTH_BITS;

	// Frame and element state.
	wrid_pkg::len_t     pos_q, len_q;
	wrid_pkg::verdict_t verdict_q;
	logic [47:0]        addr_q;
	logic signed [7:0]  rssi_q;
	wrid_pkg::phase_t   phase_q;
	logic [7:0]         elem_id_q;
	logic [7:0]         left_q;
	wrid_pkg::hmatch_t  hm_q;
	logic               stopped_q;

	// Values as seen by this byte, after a frame start has been applied.
	wrid_pkg::len_t     pos_e, len_e;
	wrid_pkg::verdict_t verdict_e, verdict_new;
	logic [47:0]        addr_e;
	logic signed [7:0]  rssi_e;
	wrid_pkg::phase_t   phase_e;
	logic [7:0]         elem_id_e;
	logic [7:0]         left_e;
	wrid_pkg::hmatch_t  hm_e;
	logic               stopped_e;

	wrid_pkg::len_t     pos_n;
	logic [47:0]        addr_n;
	wrid_pkg::phase_t   phase_n;
	logic [7:0]         elem_id_n;
	logic [7:0]         left_n;
	wrid_pkg::hmatch_t  hm_n;
	logic               stopped_n;

	logic       start, active, scan, in_elems, frame_end;
	logic [7:0] b;
	logic [3:0] subtype;
	logic       pay_hit, pay_first, pay_last;

	assign b       = item.rx_byte;
	assign start   = item_valid && item.frame_start;
	assign active  = start || (item_valid && (pos_q < len_q));
	assign subtype = b[7:4] & wrid_pkg::FC_SUBTYPE_MASK;

	// Classification from the frame length, the frame-control byte and the signal strength.
	always_comb begin
		if (item.frame_length[LB-1:0] < wrid_pkg::MIN_FRAME_LEN) begin
			verdict_new = wrid_pkg::VRD_TOO_SHORT;
		end else if ((b[3:2] & wrid_pkg::FC_TYPE_MASK) != 2'b00) begin
			verdict_new = wrid_pkg::VRD_NOT_MGMT;
		end else if (item.signal_strength < rssi_threshold) begin
			verdict_new = wrid_pkg::VRD_WEAK;
		end else begin
			case (subtype) inside
				wrid_pkg::SUB_BEACON, wrid_pkg::SUB_PROBE_RESP: begin
					verdict_new = wrid_pkg::VRD_SCANNED;
				end
				wrid_pkg::SUB_ACTION: begin
					verdict_new = wrid_pkg::VRD_ACTION;
				end
				default: begin
					verdict_new = wrid_pkg::VRD_OTHER;
				end
			endcase
		end
	end

	always_comb begin
		if (start) begin
			pos_e     = '0;
			len_e     = item.frame_length[LB-1:0];
			verdict_e = verdict_new;
			addr_e    = '0;
			rssi_e    = item.signal_strength;
			phase_e   = wrid_pkg::PH_ID;
			elem_id_e = '0;
			left_e    = '0;
			hm_e      = '0;
			stopped_e = 1'b0;
		end else begin
			pos_e     = pos_q;
			len_e     = len_q;
			verdict_e = verdict_q;
			addr_e    = addr_q;
			rssi_e    = rssi_q;
			phase_e   = phase_q;
			elem_id_e = elem_id_q;
			left_e    = left_q;
			hm_e      = hm_q;
			stopped_e = stopped_q;
		end
	end

	assign scan      = active && (verdict_e == wrid_pkg::VRD_SCANNED)
		&& (len_e >= wrid_pkg::ELEM_START);
	assign in_elems  = scan && (pos_e >= wrid_pkg::ELEM_START) && !stopped_e;
	assign frame_end = active && (({1'b0, pos_e} + (LB+1)'(1)) >= {1'b0, len_e});

	// Next state.
	always_comb begin
		pos_n     = pos_q;
		addr_n    = addr_e;
		phase_n   = phase_e;
		elem_id_n = elem_id_e;
		left_n    = left_e;
		hm_n      = hm_e;
		stopped_n = stopped_e;
		if (active) begin
			pos_n = frame_end ? len_e : pos_e + LB'(1);
		end
		if (scan && (pos_e >= wrid_pkg::ADDR_FIRST) && (pos_e <= wrid_pkg::ADDR_LAST)) begin
			addr_n = {addr_e[39:0], b};
		end
		if (in_elems) begin
			case (phase_e)
				wrid_pkg::PH_ID: begin
					elem_id_n = b;
					phase_n   = wrid_pkg::PH_LEN;
				end
				wrid_pkg::PH_LEN: begin
					// An element that runs past the frame end stops the walk.
					if (({1'b0, pos_e} + (LB+1)'(1) + (LB+1)'(b)) > {1'b0, len_e}) begin
						stopped_n = 1'b1;
						phase_n   = wrid_pkg::PH_ID;
					end else begin
						left_n  = b;
						hm_n    = ((elem_id_e == wrid_pkg::VENDOR_ID)
							&& (b >= wrid_pkg::MIN_VENDOR_LEN)) ? '0 : wrid_pkg::HM_SKIP;
						phase_n = (b != 8'd0) ? wrid_pkg::PH_BODY : wrid_pkg::PH_ID;
					end
				end
				wrid_pkg::PH_BODY: begin
					left_n = left_e - 8'd1;
					if (hm_e < wrid_pkg::HM_DONE) begin
						hm_n = wrid_pkg::header_byte_ok(hm_e[1:0], b)
							? hm_e + 4'd1 : wrid_pkg::HM_SKIP;
					end else if ((hm_e == wrid_pkg::HM_DONE) || (hm_e == wrid_pkg::HM_PAYLOAD)) begin
						hm_n = wrid_pkg::HM_PAYLOAD;
					end
					if (left_e == 8'd1) begin
						phase_n = wrid_pkg::PH_ID;
					end
				end
				default: begin
					phase_n = wrid_pkg::PH_ID;
				end
			endcase
		end
	end

	// Outputs.
	always_comb begin
		pay_hit   = in_elems && (phase_e == wrid_pkg::PH_BODY)
			&& ((hm_e == wrid_pkg::HM_DONE) || (hm_e == wrid_pkg::HM_PAYLOAD));
		pay_first = (hm_e == wrid_pkg::HM_DONE);
		pay_last  = (left_e == 8'd1);

		emit.pay_valid = pay_hit;
		emit.vrd_valid = frame_end;

		pay_res.result_kind    = wrid_pkg::KIND_PAYLOAD;
		pay_res.payload_byte   = b;
		pay_res.run_first      = pay_first;
		pay_res.run_last       = pay_last;
		pay_res.sender_address = addr_n;
		pay_res.frame_rssi     = rssi_e;
		pay_res.verdict        = verdict_e;

		vrd_res.result_kind    = wrid_pkg::KIND_VERDICT;
		vrd_res.payload_byte   = '0;
		vrd_res.run_first      = 1'b0;
		vrd_res.run_last       = 1'b0;
		vrd_res.sender_address = addr_n;
		vrd_res.frame_rssi     = rssi_e;
		vrd_res.verdict        = verdict_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			verdict_q <= wrid_pkg::VRD_TOO_SHORT;
			addr_q    <= '0;
			rssi_q    <= '0;
			phase_q   <= wrid_pkg::PH_ID;
			elem_id_q <= '0;
			left_q    <= '0;
			hm_q      <= '0;
			stopped_q <= 1'b0;
		end else if (active) begin
			pos_q     <= pos_n;
			len_q     <= len_e;
			verdict_q <= verdict_e;
			addr_q    <= addr_n;
			rssi_q    <= rssi_e;
			phase_q   <= phase_n;
			elem_id_q <= elem_id_n;
			left_q    <= left_n;
			hm_q      <= hm_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

// ----- rtl/core/wifi_remote_id_ie_locator.sv -----
// Top level of the Remote ID vendor element locator.
// A byte taken is registered at the input and parsed from that register; its results go
// into the result queue. One byte is taken per cycle while the queue has room for two
// more results; a byte ending a Remote ID element on the frame's last byte gives two
// results, which leave the result queue one per cycle while out_ready is high.
// Reset clears the parser state and queue, and sets the RSSI threshold to -90 dBm.
module wifi_remote_id_ie_locator #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wrid_pkg::in_t     in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output wrid_pkg::out_t    out_item,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data
);

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic              valid_s1;
	wrid_pkg::in_t     item_s1;
	logic signed [7:0] threshold_q;

	wrid_pkg::emit_t   emit;
	wrid_pkg::out_t    pay_res, vrd_res;
	logic [1:0]        push_cnt;
	logic [CW-1:0]     occupancy;
	logic [CW:0]       need;

	wrid_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (valid_s1),
		.item           (item_s1),
		.rssi_threshold (threshold_q),
		.emit           (emit),
		.pay_res        (pay_res),
		.vrd_res        (vrd_res)
	);

	assign push_cnt = 2'(emit.pay_valid) + 2'(emit.vrd_valid);

	// Room must remain for the worst case of two results from the next transaction.
	assign need     = {1'b0, occupancy} + (CW+1)'(push_cnt);
	assign in_ready = (need <= (CW+1)'(FIFO_DEPTH - 2));

	wrid_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push0      (emit.pay_valid ? pay_res : vrd_res),
		.push1      (vrd_res),
		.pop        (out_valid && out_ready),
		.head_valid (out_valid),
		.head       (out_item),
		.occupancy  (occupancy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			threshold_q <= wrid_pkg::RSSI_THRESHOLD_RESET;
		end else begin
			valid_s1 <= in_valid && in_ready;
			if (cfg_wr_en) begin
				threshold_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, occupancy} + (CW+1)'(push_cnt)) <= (CW+1)'(FIFO_DEPTH)))
		else $error("result queue would overflow");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_item.result_kind == wrid_pkg::KIND_VERDICT))
		|-> (!out_item.run_first && !out_item.run_last && (out_item.payload_byte == 8'd0)))
		else $error("verdict result carries payload marks");

	a_payload_scanned: assert property (@(posedge clk) disable iff (!arst_n)
		emit.pay_valid |-> (pay_res.verdict == wrid_pkg::VRD_SCANNED))
		else $error("payload byte from a frame that is not scanned");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted transaction not parsed");
`endif

endmodule
